@@ rtl/core/bia_pkg.sv @@
// Shared types and constants for the bitmap ID allocator.
`timescale 1ns / 1ps

package bia_pkg;

	typedef enum logic [2:0] {
		REQ_ALLOC  = 3'd0,
		REQ_CYCLIC = 3'd1,
		REQ_FIND   = 3'd2,
		REQ_REMOVE = 3'd3,
		REQ_CLEAR  = 3'd4
	} req_type_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK
	} state_t;

	// Free-ID search groups: one registered level per group, then a pick.
	localparam int GRP_W  = 16;
	localparam int GRP_IW = 4;

	localparam int FIELD_W = 16;
	localparam int VAL_W   = 32;
	localparam int OID_W   = 8;

endpackage

@@ rtl/core/bia_if.sv @@
// Request and response channel interfaces of the bitmap ID allocator.
`timescale 1ns / 1ps

interface bia_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         req_type;
	logic [31:0]        value_in;
	logic signed [15:0] range_start;
	logic signed [15:0] range_end;
	logic [15:0]        lookup_id;

	modport source (output valid, req_type, value_in, range_start, range_end, lookup_id,
		input ready);
	modport sink (input valid, req_type, value_in, range_start, range_end, lookup_id,
		output ready);
endinterface

interface bia_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [7:0]  id_out;
	logic [31:0] value_out;

	modport source (output valid, status, id_out, value_out, input ready);
	modport sink (input valid, status, id_out, value_out, output ready);
endinterface

@@ rtl/core/bitmap_id_allocator.sv @@
// Top level of the bitmap ID allocator: control, used bitmap and cursor.
`timescale 1ns / 1ps
// Usage:
//   req channel (sink): one request word per handshake: req_type, value_in,
//   range_start, range_end, lookup_id. rsp channel (source): one response
//   word per request: status, id_out, value_out.
//   A request is taken only when the block is idle. It then spends the scan
//   step in the registered group search (and the value table read) and the
//   pick step picking the free ID and committing the update into the
//   response register; only then does the block return to idle, so a new
//   request is not accepted before the last one has been committed.
//   The response sits in an output register; a new request is accepted while
//   it waits. If the receiver stalls while the next result is ready, that
//   result holds in the pick step and nothing is committed until the output
//   register frees up.
//   Reset clears the used bitmap, the cyclic cursor and all control state;
//   the value table is not cleared and is only read for IDs in use.
module bitmap_id_allocator
	import bia_pkg::*;
#(
	parameter int ENTRIES     = 256,
	parameter int VALUE_WIDTH = 32
) (
	input  logic  clk,
	input  logic  arst_n,
	bia_req_if.sink   req,
	bia_rsp_if.source rsp
);

	localparam int IDW = $clog2(ENTRIES);

	state_t             state_q;
	state_t             state_d;

	req_type_t          req_q;
	logic [VAL_W-1:0]   value_q;
	logic [15:0]        s_q;
	logic [15:0]        e_q;
	logic [15:0]        look_q;

	logic [ENTRIES-1:0] used_q;
	logic [IDW-1:0]     cursor_q;

	logic               out_valid_q;
	logic               status_q;
	logic [OID_W-1:0]   id_q;
	logic [VAL_W-1:0]   val_q;

	logic               accept;
	logic               out_free;
	logic               commit;

	logic [15:0]        s_clamp;
	logic [15:0]        e_clamp;
	logic [15:0]        cur16;
	logic [15:0]        lo;

	logic               hit;
	logic [IDW-1:0]     hit_id;
	logic [IDW:0]       nxt_cur;

	logic [IDW-1:0]     look_idx;
	logic               look_ok;
	logic [VALUE_WIDTH-1:0] rdata;
	logic [63:0]        rd_ext;

	logic               res_ok;
	logic               grant;
	logic               fetch;
	logic               drop;
	logic               wipe;

	// FSM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				state_d = ST_PICK;
			end
			ST_PICK: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_free = !out_valid_q || rsp.ready;

	always_comb begin
		req.ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: req.ready = 1'b1;
			ST_SCAN: ;
			ST_PICK: commit = out_free;
			default: ;
		endcase
	end

	assign accept = req.valid && req.ready;

	// request capture with range clamping
	assign s_clamp = req.range_start[15] ? '0 : 16'(req.range_start);
	assign e_clamp = (req.range_end[15] || 16'(req.range_end) > 16'(ENTRIES))
		? 16'(ENTRIES) : 16'(req.range_end);

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req_type_t'(req.req_type);
			value_q <= req.value_in;
			s_q     <= s_clamp;
			e_q     <= e_clamp;
			look_q  <= req.lookup_id;
		end
	end

	// cyclic search starts at the cursor when it lies inside the range
	assign cur16 = 16'(cursor_q);
	assign lo    = (req_q == REQ_CYCLIC && cur16 >= s_q && cur16 < e_q) ? cur16 : s_q;

	bia_search #(
		.ENTRIES (ENTRIES),
		.IDW     (IDW)
	) u_search (
		.clk    (clk),
		.used   (used_q),
		.lo     (lo),
		.s      (s_q),
		.e      (e_q),
		.hit    (hit),
		.hit_id (hit_id)
	);

	assign look_idx = look_q[IDW-1:0];
	assign look_ok  = look_q < 16'(ENTRIES);

	bia_value_mem #(
		.DEPTH (ENTRIES),
		.WIDTH (VALUE_WIDTH),
		.AW    (IDW)
	) u_mem (
		.clk   (clk),
		.we    (commit && grant),
		.waddr (hit_id),
		.wdata (VALUE_WIDTH'(value_q)),
		.raddr (look_idx),
		.rdata (rdata)
	);

	assign rd_ext = 64'(rdata);

	always_comb begin
		res_ok = 1'b0;
		grant  = 1'b0;
		fetch  = 1'b0;
		drop   = 1'b0;
		wipe   = 1'b0;
		case (req_q) inside
			REQ_ALLOC, REQ_CYCLIC: begin
				if (value_q != '0 && s_q < e_q && hit) begin
					res_ok = 1'b1;
					grant  = 1'b1;
				end
			end
			REQ_FIND, REQ_REMOVE: begin
				if (look_ok && used_q[look_idx]) begin
					res_ok = 1'b1;
					fetch  = 1'b1;
					drop   = (req_q == REQ_REMOVE);
				end
			end
			REQ_CLEAR: begin
				res_ok = 1'b1;
				wipe   = 1'b1;
			end
			default: ;
		endcase
	end

	assign nxt_cur = {1'b0, hit_id} + (IDW+1)'(1);

	// bitmap and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			cursor_q <= '0;
		end else if (commit) begin
			if (wipe) begin
				used_q   <= '0;
				cursor_q <= '0;
			end
			if (grant) begin
				used_q[hit_id] <= 1'b1;
				if (req_q == REQ_CYCLIC) begin
					cursor_q <= (16'(nxt_cur) < e_q) ? nxt_cur[IDW-1:0] : s_q[IDW-1:0];
				end
			end
			if (drop) begin
				used_q[look_idx] <= 1'b0;
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			status_q <= !res_ok;
			id_q     <= grant ? OID_W'(hit_id) : '0;
			val_q    <= fetch ? rd_ext[VAL_W-1:0] : '0;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = status_q;
	assign rsp.id_out    = id_q;
	assign rsp.value_out = val_q;

`ifndef NO_ASSERTIONS
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		commit && grant |-> !used_q[hit_id])
		else $error("granted ID already in use");

	a_grant_range: assert property (@(posedge clk) disable iff (!arst_n)
		commit && grant |-> (16'(hit_id) >= s_q) && (16'(hit_id) < e_q))
		else $error("granted ID outside range");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		commit && wipe |=> (used_q == '0) && (cursor_q == '0))
		else $error("clear left state behind");

	a_rsp_from_pick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(state_q == ST_PICK))
		else $error("response raised outside pick step");

	a_cursor_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q < IDW'(ENTRIES - 1) || cursor_q == IDW'(ENTRIES - 1))
		else $error("cursor beyond capacity");
`endif

endmodule

@@ rtl/core/bia_value_mem.sv @@
// Value table: single write port, single read port, registered read data.
`timescale 1ns / 1ps

module bia_value_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/bia_search.sv @@
// Two-level free-ID search: registered per-group lowest free, then group pick.
`timescale 1ns / 1ps

module bia_search
	import bia_pkg::*;
#(
	parameter int ENTRIES = 256,
	parameter int IDW     = 8
) (
	input  logic               clk,
	input  logic [ENTRIES-1:0] used,
	input  logic [15:0]        lo,
	input  logic [15:0]        s,
	input  logic [15:0]        e,
	output logic               hit,
	output logic [IDW-1:0]     hit_id
);

	localparam int NG   = (ENTRIES + GRP_W - 1) / GRP_W;
	localparam int PADW = NG * GRP_W;
	localparam int PW   = $clog2(PADW);

	logic [PADW-1:0]   free_pad;
	logic [PADW-1:0]   in_a;
	logic [PADW-1:0]   in_b;
	logic              any_a [NG];
	logic              any_b [NG];
	logic [GRP_IW-1:0] idx_a [NG];
	logic [GRP_IW-1:0] idx_b [NG];

	logic              any_a_s1 [NG];
	logic              any_b_s1 [NG];
	logic [GRP_IW-1:0] idx_a_s1 [NG];
	logic [GRP_IW-1:0] idx_b_s1 [NG];

	logic              fa;
	logic              fb;
	logic [PW-1:0]     id_a;
	logic [PW-1:0]     id_b;

	assign free_pad = PADW'(~used);

	always_comb begin
		for (int i = 0; i < PADW; i++) begin
			in_a[i] = free_pad[i] && (16'(i) >= lo) && (16'(i) < e);
			in_b[i] = free_pad[i] && (16'(i) >= s) && (16'(i) < e);
		end
	end

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			any_a[g] = 1'b0;
			any_b[g] = 1'b0;
			idx_a[g] = '0;
			idx_b[g] = '0;
			for (int b = GRP_W - 1; b >= 0; b--) begin
				if (in_a[g*GRP_W + b]) begin
					any_a[g] = 1'b1;
					idx_a[g] = GRP_IW'(b);
				end
				if (in_b[g*GRP_W + b]) begin
					any_b[g] = 1'b1;
					idx_b[g] = GRP_IW'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int g = 0; g < NG; g++) begin
			any_a_s1[g] <= any_a[g];
			any_b_s1[g] <= any_b[g];
			idx_a_s1[g] <= idx_a[g];
			idx_b_s1[g] <= idx_b[g];
		end
	end

	always_comb begin
		fa   = 1'b0;
		fb   = 1'b0;
		id_a = '0;
		id_b = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (any_a_s1[g]) begin
				fa   = 1'b1;
				id_a = (PW'(g) << GRP_IW) | PW'(idx_a_s1[g]);
			end
			if (any_b_s1[g]) begin
				fb   = 1'b1;
				id_b = (PW'(g) << GRP_IW) | PW'(idx_b_s1[g]);
			end
		end
	end

	// search from lo first, wrap to s when nothing at or above lo
	assign hit    = fa || fb;
	assign hit_id = fa ? IDW'(id_a) : IDW'(id_b);

endmodule
